/* hw/rtl/mt19937_keystream_byte_decrypt_unit_macros.svh */
// Assertion macros shared by the keystream decrypt unit.
// Every module that uses them has i_clk and i_rst_n in scope.
`ifndef MT19937_KEYSTREAM_BYTE_DECRYPT_UNIT_MACROS_SVH
`define MT19937_KEYSTREAM_BYTE_DECRYPT_UNIT_MACROS_SVH

// Same-cycle implication.
`define MTKD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mtkd: same-cycle check failed");

// Next-cycle implication.
`define MTKD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mtkd: next-cycle check failed");

`endif

/* hw/rtl/mtkd_pkg.sv */
package mtkd_pkg;

    localparam int TW_N   = 624;
    localparam int TW_M   = 397;
    localparam int IDX_W  = 10;
    localparam int WORD_W = 32;

    localparam logic [31:0] SEED_XOR   = 32'hA9C36DE1;
    localparam int          SEED_SHIFT = 7;
    localparam logic [31:0] INIT_MULT  = 32'd1812433253;
    localparam logic [31:0] MATRIX_A   = 32'h9908B0DF;
    localparam logic [31:0] TEMPER_B   = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C   = 32'hEFC60000;

    // Register map.
    localparam logic REG_ENTRY_SEED = 1'b0;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic seed_start;
        logic seed_mul;
        logic seed_wr;
        logic rd_far;
        logic twist;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic seed_last;
    } t_dp_sts;

    function automatic t_word temper(input t_word w);
        t_word y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

/* hw/rtl/mtkd_ram.sv */
module mtkd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

/* hw/rtl/mtkd_ctrl.sv */
`include "mt19937_keystream_byte_decrypt_unit_macros.svh"

module mtkd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output mtkd_pkg::t_dp_cmd o_cmd,
    input  mtkd_pkg::t_dp_sts i_sts
);
    import mtkd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_MUL,
        S_SEED_WR,
        S_RD_PAIR,
        S_RD_FAR,
        S_TWIST,
        S_EMIT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_needs_seed;
    logic    r_out_valid;
    logic    accept;
    logic    out_free;
    t_dp_cmd cmd;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture    = 1'b1;
                    cmd.seed_start = r_needs_seed;
                    n_state        = r_needs_seed ? S_SEED_MUL : S_RD_PAIR;
                end
            end
            S_SEED_MUL: begin
                cmd.seed_mul = 1'b1;
                n_state      = S_SEED_WR;
            end
            S_SEED_WR: begin
                cmd.seed_wr = 1'b1;
                n_state     = i_sts.seed_last ? S_RD_PAIR : S_SEED_MUL;
            end
            S_RD_PAIR: begin
                n_state = S_RD_FAR;
            end
            S_RD_FAR: begin
                cmd.rd_far = 1'b1;
                n_state    = S_TWIST;
            end
            S_TWIST: begin
                cmd.twist = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_needs_seed <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // The entry that a last beat closes is re-seeded on the next beat.
            if (accept) begin
                r_needs_seed <= i_in_last;
            end
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `MTKD_ASSERT_IMPL(a_load_when_free, cmd.out_load, out_free)
    `MTKD_ASSERT_NEXT(a_last_reseeds, accept && i_in_last, r_needs_seed)
    `MTKD_ASSERT_NEXT(a_seed_loops, (r_state == S_SEED_WR) && !i_sts.seed_last,
        r_state == S_SEED_MUL)
    `MTKD_ASSERT_NEXT(a_stalled_result_holds, r_out_valid && i_out_stall, r_out_valid)

endmodule

/* hw/rtl/mtkd_datapath.sv */
`include "mt19937_keystream_byte_decrypt_unit_macros.svh"

module mtkd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtkd_pkg::t_dp_cmd i_cmd,
    output mtkd_pkg::t_dp_sts o_sts,
    input  mtkd_pkg::t_word   i_entry_seed,
    input  logic [7:0]        i_cipher_byte,
    input  logic              i_last_byte,
    output logic [7:0]        o_plain_byte,
    output logic              o_last_out,
    output logic              o_wr_en,
    output mtkd_pkg::t_idx    o_wr_addr,
    output mtkd_pkg::t_word   o_wr_data,
    output mtkd_pkg::t_idx    o_rd_addr_a,
    output mtkd_pkg::t_idx    o_rd_addr_b,
    input  mtkd_pkg::t_word   i_rd_data_a,
    input  mtkd_pkg::t_word   i_rd_data_b
);
    import mtkd_pkg::*;

    t_idx       r_idx;
    t_word      r_prev;
    t_word      r_prod;
    t_word      r_y;
    logic [7:0] r_cipher;
    logic       r_last;
    logic [7:0] r_plain;
    logic [7:0] r_out_plain;
    logic       r_out_last;

    t_idx  idx_p1;
    t_idx  idx_pm;
    t_word seed_val;
    t_word seed_word;
    t_word twisted;
    t_word keystream;
    logic  seed_last;

    assign idx_p1 = (r_idx == IDX_W'(TW_N - 1)) ? '0 : r_idx + IDX_W'(1);
    assign idx_pm = (r_idx >= IDX_W'(TW_N - TW_M)) ? r_idx - IDX_W'(TW_N - TW_M)
                                                    : r_idx + IDX_W'(TW_M);

    assign seed_val  = (i_entry_seed << SEED_SHIFT) ^ SEED_XOR;
    assign seed_word = r_prod + {{(WORD_W - IDX_W){1'b0}}, r_idx};
    assign seed_last = (r_idx == IDX_W'(TW_N - 1));

    // At twist time the far word is on port A; r_y holds the merged pair.
    assign twisted   = i_rd_data_a ^ (r_y >> 1) ^ (r_y[0] ? MATRIX_A : '0);
    assign keystream = temper(twisted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.seed_start) begin
            r_idx <= IDX_W'(1);
        end else if (i_cmd.seed_wr) begin
            r_idx <= seed_last ? '0 : r_idx + IDX_W'(1);
        end else if (i_cmd.twist) begin
            r_idx <= idx_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cipher <= i_cipher_byte;
            r_last   <= i_last_byte;
        end
        if (i_cmd.seed_start) begin
            r_prev <= seed_val;
        end else if (i_cmd.seed_wr) begin
            r_prev <= seed_word;
        end
        if (i_cmd.seed_mul) begin
            r_prod <= INIT_MULT * (r_prev ^ (r_prev >> 30));
        end
        if (i_cmd.rd_far) begin
            r_y <= {i_rd_data_a[WORD_W-1], i_rd_data_b[WORD_W-2:0]};
        end
        if (i_cmd.twist) begin
            r_plain <= r_cipher ^ keystream[7:0];
        end
        if (i_cmd.out_load) begin
            r_out_plain <= r_plain;
            r_out_last  <= r_last;
        end
    end

    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx;
        o_wr_data = twisted;
        if (i_cmd.seed_start) begin
            o_wr_en   = 1'b1;
            o_wr_addr = '0;
            o_wr_data = seed_val;
        end else if (i_cmd.seed_wr) begin
            o_wr_en   = 1'b1;
            o_wr_data = seed_word;
        end else if (i_cmd.twist) begin
            o_wr_en = 1'b1;
        end
    end

    assign o_rd_addr_a     = i_cmd.rd_far ? idx_pm : r_idx;
    assign o_rd_addr_b     = idx_p1;
    assign o_sts.seed_last = seed_last;
    assign o_plain_byte    = r_out_plain;
    assign o_last_out      = r_out_last;

    `MTKD_ASSERT_IMPL(a_idx_in_range, 1'b1, r_idx < IDX_W'(TW_N))
    `MTKD_ASSERT_NEXT(a_seed_end_rewinds, i_cmd.seed_wr && seed_last, r_idx == '0)
    `MTKD_ASSERT_NEXT(a_twist_advances, i_cmd.twist, r_idx == $past(idx_p1))

endmodule

/* hw/rtl/mt19937_keystream_byte_decrypt_unit.sv */
// Each accepted byte passes through the pair read, far read, twist and emit states; the
// first beat of an entry first seeds generator words 1 to 623 in seed multiply and seed
// write state pairs. No new byte is taken until the previous one leaves emit, which
// holds while the output stalls; memory port A reads twice a byte, port B and the write once.
// Reset (synchronous, active low) clears entry_seed and arms seeding for the next beat.
`include "mt19937_keystream_byte_decrypt_unit_macros.svh"

module mt19937_keystream_byte_decrypt_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_cipher_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_plain_byte,
    output logic        o_last_out
);
    import mtkd_pkg::*;

    t_word   r_entry_seed;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    wr_en;
    t_idx    wr_addr;
    t_word   wr_data;
    t_idx    rd_addr_a;
    t_idx    rd_addr_b;
    t_word   rd_data_a;
    t_word   rd_data_b;
    logic    reg_sel;

    assign reg_sel = (paddr[2] == REG_ENTRY_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_seed <= '0;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_entry_seed <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_sel ? r_entry_seed : '0;

    mtkd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_last_byte),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mtkd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_entry_seed  (r_entry_seed),
        .i_cipher_byte (i_cipher_byte),
        .i_last_byte   (i_last_byte),
        .o_plain_byte  (o_plain_byte),
        .o_last_out    (o_last_out),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_addr_a   (rd_addr_a),
        .o_rd_addr_b   (rd_addr_b),
        .i_rd_data_a   (rd_data_a),
        .i_rd_data_b   (rd_data_b)
    );

    mtkd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TW_N)
    ) u_words (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    `MTKD_ASSERT_NEXT(a_seed_write, psel && penable && pwrite && reg_sel,
        r_entry_seed == $past(pwdata))
    `MTKD_ASSERT_IMPL(a_busy_while_result, o_out_valid && i_out_stall && o_in_stall,
        !cmd.capture)
    `MTKD_ASSERT_IMPL(a_mem_write_in_range, wr_en, wr_addr < IDX_W'(TW_N))

endmodule
